// ===== hdl/rtdt_pkg.sv =====
// rtdt_pkg: shared types, constants and cell schedule for the rtd code to temperature unit
// no dependencies
package rtdt_pkg;

  localparam int unsigned TEMP_FRAC_BITS = 8;
  localparam int unsigned TEMP_SHIFT     = 7 + TEMP_FRAC_BITS;
  localparam int unsigned TEMP_W         = 21;
  localparam int unsigned RES_W          = 32;
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned CFG_W          = 28;
  localparam int unsigned FULL_BASE      = 13;
  localparam int unsigned E_SHIFT        = 26;
  localparam int unsigned E_CAP_BIT      = 62;
  localparam int unsigned E_NEG_BIT      = 57;

  localparam int unsigned DIV1_STEPS = RES_W;
  localparam int unsigned DIV2_STEPS = E_CAP_BIT;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV3_STEPS = TEMP_W;

  localparam int unsigned P_LOAD     = 0;
  localparam int unsigned P_DIV1_SET = 1;
  localparam int unsigned P_DIV1     = 2;
  localparam int unsigned P_RES      = P_DIV1 + DIV1_STEPS;
  localparam int unsigned P_MUL      = P_RES + 1;
  localparam int unsigned P_DIV2_SET = P_MUL + 1;
  localparam int unsigned P_DIV2     = P_DIV2_SET + 1;
  localparam int unsigned P_MAG      = P_DIV2 + DIV2_STEPS;
  localparam int unsigned P_DISC     = P_MAG + 1;
  localparam int unsigned P_SQRT     = P_DISC + 1;
  localparam int unsigned P_NUM      = P_SQRT + SQRT_STEPS;
  localparam int unsigned P_DIV3_SET = P_NUM + 1;
  localparam int unsigned P_DIV3     = P_DIV3_SET + 1;
  localparam int unsigned P_FINAL    = P_DIV3 + DIV3_STEPS;
  localparam int unsigned NUM_CELLS  = P_FINAL + 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NOROOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_SERIES = 3'd0,
    CFG_R0     = 3'd1,
    CFG_A      = 3'd2,
    CFG_B      = 3'd3,
    CFG_SHIFT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_DIV1_SET,
    OP_DIV_STEP,
    OP_RES,
    OP_MUL,
    OP_DIV2_SET,
    OP_MAG,
    OP_DISC,
    OP_SQRT_STEP,
    OP_NUM,
    OP_DIV3_SET,
    OP_FINAL
  } cell_op_t;

  typedef struct packed {
    logic [15:0]        series;
    logic [15:0]        r0;
    logic [27:0]        a;
    logic signed [24:0] b;
    logic [3:0]         sh;
  } cfg_t;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] r;
    logic [61:0] q;
    logic [24:0] d;
    logic [31:0] res;
    status_t     status;
    logic        sat;
    logic        neg;
    logic        ge;
    logic        nz;
  } tok_t;

  function automatic cell_op_t cell_op(input int unsigned p);
    cell_op_t op;
    if (p == P_LOAD) op = OP_LOAD;
    else if (p == P_DIV1_SET) op = OP_DIV1_SET;
    else if (p < P_RES) op = OP_DIV_STEP;
    else if (p == P_RES) op = OP_RES;
    else if (p == P_MUL) op = OP_MUL;
    else if (p == P_DIV2_SET) op = OP_DIV2_SET;
    else if (p < P_MAG) op = OP_DIV_STEP;
    else if (p == P_MAG) op = OP_MAG;
    else if (p == P_DISC) op = OP_DISC;
    else if (p < P_NUM) op = OP_SQRT_STEP;
    else if (p == P_NUM) op = OP_NUM;
    else if (p == P_DIV3_SET) op = OP_DIV3_SET;
    else if (p < P_FINAL) op = OP_DIV_STEP;
    else op = OP_FINAL;
    return op;
  endfunction

endpackage

// ===== hdl/rtdt_if.sv =====
// rtdt_in_if, rtdt_out_if: valid/ready channels for codes and results
// depends on nothing
interface rtdt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_code;
  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface rtdt_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] temperature;
  logic [31:0]        resistance_ohms;
  logic [1:0]         status;
  modport source (output valid, output temperature, output resistance_ohms, output status,
                  input ready);
  modport sink (input valid, input temperature, input resistance_ohms, input status,
                output ready);
endinterface

// ===== hdl/rtdt_cell.sv =====
// rtdt_cell: one pipeline cell, performs one step of the conversion and holds a token
// depends on rtdt_pkg
module rtdt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rtdt_pkg::cfg_t    cfg,
  input  rtdt_pkg::cell_op_t op,
  input  logic              in_valid,
  output logic              in_ready,
  input  rtdt_pkg::tok_t    in_tok,
  output logic              out_valid,
  input  logic              out_ready,
  output rtdt_pkg::tok_t    out_tok
);

  logic           v_r;
  rtdt_pkg::tok_t tok_r;
  rtdt_pkg::tok_t tok_nxt;

  always_comb begin
    logic [15:0]        code;
    logic [28:0]        full;
    logic [28:0]        diff;
    logic [44:0]        prod;
    logic [34:0]        rr;
    logic [35:0]        rs;
    logic [35:0]        trial;
    logic [15:0]        r0e;
    logic [24:0]        babs;
    logic [31:0]        resv;
    logic signed [32:0] qs;
    logic [31:0]        qabs;
    logic [56:0]        m;
    logic [62:0]        mag;
    logic [63:0]        disc;
    logic signed [33:0] nums;
    logic [31:0]        nabs;
    logic [42:0]        hi;
    logic [20:0]        qm;
    logic [20:0]        temp;
    tok_nxt = in_tok;
    code  = in_tok.n[15:0];
    full  = 29'd1 << (5'(cfg.sh) + 5'(rtdt_pkg::FULL_BASE));
    diff  = full - 29'(code);
    prod  = 45'(cfg.series) * 45'(diff);
    rr    = {in_tok.r, in_tok.n[63]};
    rs    = {in_tok.r, in_tok.n[63:62]};
    trial = {2'b00, in_tok.q[31:0], 2'b01};
    r0e   = (cfg.r0 == 16'd0) ? 16'd1 : cfg.r0;
    babs  = cfg.b[24] ? 25'(-cfg.b) : 25'(cfg.b);
    resv  = in_tok.res;
    if (in_tok.status == rtdt_pkg::ST_OK) begin
      resv = in_tok.ge ? 32'd0 : (in_tok.sat ? '1 : in_tok.q[31:0]);
    end
    qs    = $signed({17'b0, r0e}) - $signed({1'b0, resv});
    qabs  = qs[32] ? 32'(-qs) : qs[31:0];
    m     = in_tok.n[56:0];
    mag   = in_tok.sat ? (63'd1 << rtdt_pkg::E_CAP_BIT) : 63'(in_tok.q);
    disc  = (in_tok.neg && in_tok.nz) ? 64'(in_tok.q) - in_tok.n : 64'(in_tok.q) + in_tok.n;
    nums  = $signed({2'b0, in_tok.q[31:0]}) - $signed({6'b0, cfg.a});
    nabs  = nums[33] ? 32'(-nums) : nums[31:0];
    hi    = in_tok.n[63:rtdt_pkg::DIV3_STEPS];
    qm    = in_tok.q[20:0];
    temp  = '0;
    case (op)
      rtdt_pkg::OP_LOAD: begin
        tok_nxt     = '0;
        tok_nxt.d   = 25'(code);
        tok_nxt.ge  = 29'(code) >= full;
        tok_nxt.n   = 64'(prod);
        if (code == 16'd0) begin
          tok_nxt.status = rtdt_pkg::ST_ZERO;
          tok_nxt.res    = '1;
        end else begin
          tok_nxt.status = rtdt_pkg::ST_OK;
        end
      end
      rtdt_pkg::OP_DIV1_SET: begin
        tok_nxt.sat = 25'(in_tok.n[44:32]) >= in_tok.d;
        tok_nxt.r   = 34'(in_tok.n[44:32]);
        tok_nxt.n   = {in_tok.n[31:0], 32'b0};
        tok_nxt.q   = '0;
      end
      rtdt_pkg::OP_DIV_STEP: begin
        if (rr >= 35'(in_tok.d)) begin
          tok_nxt.r = 34'(rr - 35'(in_tok.d));
          tok_nxt.q = {in_tok.q[60:0], 1'b1};
        end else begin
          tok_nxt.r = rr[33:0];
          tok_nxt.q = {in_tok.q[60:0], 1'b0};
        end
        tok_nxt.n = {in_tok.n[62:0], 1'b0};
      end
      rtdt_pkg::OP_RES: begin
        tok_nxt.res = resv;
        if (in_tok.status == rtdt_pkg::ST_OK && cfg.b == 25'sd0) begin
          tok_nxt.status = rtdt_pkg::ST_NOROOT;
        end
        tok_nxt.d   = babs;
        tok_nxt.neg = cfg.b[24] == qs[32];
        tok_nxt.nz  = qabs != 32'd0;
        tok_nxt.n   = 64'(qabs);
      end
      rtdt_pkg::OP_MUL: begin
        tok_nxt.n = 64'(57'(in_tok.d) * 57'(in_tok.n[31:0]));
      end
      rtdt_pkg::OP_DIV2_SET: begin
        tok_nxt.sat = 21'(m[56:36]) >= 21'(r0e);
        tok_nxt.r   = 34'(m[56:36]);
        tok_nxt.n   = {m[35:0], 28'b0};
        tok_nxt.d   = 25'(r0e);
        tok_nxt.q   = '0;
      end
      rtdt_pkg::OP_MAG: begin
        if (in_tok.status == rtdt_pkg::ST_OK && in_tok.neg && in_tok.nz &&
            mag > (63'd1 << rtdt_pkg::E_NEG_BIT)) begin
          tok_nxt.status = rtdt_pkg::ST_NOROOT;
        end
        tok_nxt.n = 64'(mag);
        tok_nxt.q = 62'(56'(cfg.a) * 56'(cfg.a));
      end
      rtdt_pkg::OP_DISC: begin
        if (in_tok.status == rtdt_pkg::ST_OK && disc[63]) begin
          tok_nxt.status = rtdt_pkg::ST_NOROOT;
        end
        tok_nxt.n = disc;
        tok_nxt.r = '0;
        tok_nxt.q = '0;
      end
      rtdt_pkg::OP_SQRT_STEP: begin
        if (rs >= trial) begin
          tok_nxt.r = 34'(rs - trial);
          tok_nxt.q = {in_tok.q[60:0], 1'b1};
        end else begin
          tok_nxt.r = rs[33:0];
          tok_nxt.q = {in_tok.q[60:0], 1'b0};
        end
        tok_nxt.n = {in_tok.n[61:0], 2'b00};
      end
      rtdt_pkg::OP_NUM: begin
        tok_nxt.neg = nums[33] ^ cfg.b[24];
        tok_nxt.n   = 64'(nabs) << rtdt_pkg::TEMP_SHIFT;
      end
      rtdt_pkg::OP_DIV3_SET: begin
        tok_nxt.sat = hi >= 43'(babs);
        tok_nxt.r   = 34'(hi);
        tok_nxt.n   = in_tok.n << (64 - rtdt_pkg::DIV3_STEPS);
        tok_nxt.d   = babs;
        tok_nxt.q   = '0;
      end
      rtdt_pkg::OP_FINAL: begin
        if (!in_tok.neg) begin
          temp = (in_tok.sat || qm[20]) ? 21'h0FFFFF : qm;
        end else begin
          temp = (in_tok.sat || qm > 21'h100000) ? 21'h100000 : 21'(-qm);
        end
        tok_nxt.n = (in_tok.status == rtdt_pkg::ST_OK) ? 64'(temp) : 64'd0;
      end
      default: begin
        tok_nxt = in_tok;
      end
    endcase
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

// ===== hdl/rtd_code_to_temperature_unit.sv =====
// rtd_code_to_temperature_unit: top level, config registers and the row of conversion cells
// depends on rtdt_pkg, rtdt_if, rtdt_cell
// 157 cells in a row; each division step, square root bit and multiply has its own cell
// throughput: one code per cycle while the output is not stalled
// a stalled result holds the last cell, earlier cells keep filling bubbles until they are full
// reset: synchronous, clears all cell valid flags and loads the default coefficients
module rtd_code_to_temperature_unit (
  input  logic        clk,
  input  logic        rst_n,
  rtdt_in_if.sink     in_ch,
  rtdt_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [27:0] cfg_wdata
);

  localparam int unsigned N = rtdt_pkg::NUM_CELLS;

  rtdt_pkg::cfg_t cfg_r;
  logic           v   [N+1];
  logic           rdy [N+1];
  rtdt_pkg::tok_t tok [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.series <= 16'd989;
      cfg_r.r0     <= 16'd1000;
      cfg_r.a      <= 28'd16786021;
      cfg_r.b      <= -25'sd634968;
      cfg_r.sh     <= 4'd4;
    end else if (cfg_we) begin
      case (rtdt_pkg::cfg_idx_t'(cfg_idx))
        rtdt_pkg::CFG_SERIES: cfg_r.series <= cfg_wdata[15:0];
        rtdt_pkg::CFG_R0:     cfg_r.r0     <= cfg_wdata[15:0];
        rtdt_pkg::CFG_A:      cfg_r.a      <= cfg_wdata[27:0];
        rtdt_pkg::CFG_B:      cfg_r.b      <= $signed(cfg_wdata[24:0]);
        rtdt_pkg::CFG_SHIFT:  cfg_r.sh     <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tok[0]   = '0;
    tok[0].n = 64'(in_ch.adc_code);
  end
  assign v[0]        = in_ch.valid;
  assign in_ch.ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam rtdt_pkg::cell_op_t OP = rtdt_pkg::cell_op(i);
    rtdt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg_r),
      .op        (OP),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_tok    (tok[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .out_tok   (tok[i+1])
    );
  end

  assign rdy[N]                 = out_ch.ready;
  assign out_ch.valid           = v[N];
  assign out_ch.temperature     = $signed(tok[N].n[20:0]);
  assign out_ch.resistance_ohms = tok[N].res;
  assign out_ch.status          = tok[N].status;

  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == rtdt_pkg::ST_ZERO |->
      out_ch.resistance_ohms == 32'hFFFFFFFF && out_ch.temperature == 21'sd0)
    else $error("zero code result malformed");

  a_noroot_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == rtdt_pkg::ST_NOROOT |-> out_ch.temperature == 21'sd0)
    else $error("no root result has nonzero temperature");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input blocked without output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
